// ----- rtl/core/sgb_pkg.sv -----
// Shared types, constants and arithmetic helpers of the separable Gaussian blur core.
package sgb_pkg;

    localparam int CHANNEL_BITS    = 16;
    localparam int DEF_MAX_WIDTH   = 2048;
    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HEIGHT_BITS = 15;
    localparam int ROW_BITS        = 15;
    localparam int HEIGHT_LIMIT    = 16384;
    localparam int RESET_WIDTH     = 2048;
    localparam int RESET_HEIGHT    = 1080;
    localparam int ROW_SLOTS       = 8;
    localparam int SLOT_BITS       = 3;
    localparam int TAPS            = 5;
    localparam int WEIGHT_BITS     = 15;
    localparam int PROD_BITS       = CHANNEL_BITS + WEIGHT_BITS;
    localparam int SUM_BITS        = PROD_BITS + 3;
    localparam int FRAC_BITS       = 16;
    localparam int PIX_BITS        = 3 * CHANNEL_BITS;
    localparam int CMD_DEPTH       = 4;
    localparam int OUT_DEPTH       = 8;

    localparam logic [TAPS-1:0][WEIGHT_BITS-1:0] TAP_WEIGHT =
        {15'd7871, 15'd15329, 15'd19209, 15'd15329, 15'd7871};
    localparam logic [SUM_BITS-1:0] ROUND_CONST = SUM_BITS'(32768);
    localparam logic [SUM_BITS-1:0] CH_MAX      = SUM_BITS'({CHANNEL_BITS{1'b1}});

    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef t_chan [2:0]             t_pix;
    typedef t_pix [TAPS-1:0]         t_win;
    typedef logic [PROD_BITS-1:0]    t_prod;
    typedef t_prod [TAPS-1:0]        t_prods;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg;

    typedef struct packed {
        logic [2:0]                     wr_mask;
        logic [SLOT_BITS-1:0]           wr_slot;
        t_win                           win;
        logic                           rd;
        logic [TAPS-1:0][SLOT_BITS-1:0] rd_slot;
        logic                           last;
    } t_cmd;

    typedef struct packed {
        logic last;
        t_pix pix;
    } t_res;

    function automatic t_prods weigh_taps(input t_chan [TAPS-1:0] v);
        t_prods p;
        for (int i = 0; i < TAPS; i++) begin
            p[i] = PROD_BITS'(v[i]) * PROD_BITS'(TAP_WEIGHT[i]);
        end
        return p;
    endfunction

    function automatic t_chan round_sat(input t_prods p);
        logic [SUM_BITS-1:0] acc;
        acc = ROUND_CONST;
        for (int i = 0; i < TAPS; i++) begin
            acc = acc + SUM_BITS'(p[i]);
        end
        acc = acc >> FRAC_BITS;
        if (acc > CH_MAX) begin
            acc = CH_MAX;
        end
        return acc[CHANNEL_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/sgb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sgb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sgb_fifo.sv -----
// Small register-based FIFO used for the command queue and the result buffer.
module sgb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty,
    output logic             o_full,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

    assign o_dout  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;

endmodule

// ----- rtl/core/sgb_front.sv -----
// Front end: accepts items, keeps frame position and pixel window, issues line-buffer commands.
module sgb_front
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int LAG_W = $clog2(2 * MAX_WIDTH + 3)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic [WW-1:0]       i_w,
    input  logic [ROW_BITS-1:0] i_h,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  t_chan               i_red,
    input  t_chan               i_green,
    input  t_chan               i_blue,
    input  logic                i_q_full,
    output logic                o_push,
    output t_cmd                o_cmd,
    output logic [COL_W-1:0]    o_wr_col,
    output logic [COL_W-1:0]    o_rd_col
);

    logic [COL_W-1:0]    r_in_col, n_in_col;
    logic [ROW_BITS-1:0] r_in_row, n_in_row;
    logic [LAG_W-1:0]    r_lag, n_lag;
    logic [COL_W-1:0]    r_out_x, n_out_x;
    logic [ROW_BITS-1:0] r_out_y, n_out_y;
    t_win                r_win, n_win;

    logic       accept, pix_phase, ignore, pix, c_end, lag_full, x_end, y_end;
    t_pix       p;
    t_win       win1;
    logic [2:0] mask;
    logic       rd;
    logic [TAPS-1:0][SLOT_BITS-1:0] rd_slot;
    logic signed [ROW_BITS+1:0] rr;
    logic signed [ROW_BITS+1:0] hmax;

    assign accept    = i_valid && !i_q_full;
    assign o_ready   = !i_q_full;
    assign pix_phase = r_in_row < i_h;
    assign ignore    = pix_phase && (t_op'(i_op) == OP_DRAIN);
    assign pix       = pix_phase && (t_op'(i_op) == OP_PIXEL);
    assign p         = {i_blue, i_green, i_red};
    assign c_end     = (WW'(r_in_col) + WW'(1)) >= i_w;
    assign lag_full  = r_lag >= (LAG_W'({i_w, 1'b0}) + LAG_W'(2));
    assign x_end     = (WW'(r_out_x) == (i_w - WW'(1)));
    assign y_end     = (r_out_y == (i_h - ROW_BITS'(1)));
    assign hmax      = $signed({2'b00, i_h}) - (ROW_BITS+2)'(1);

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            rr = $signed({2'b00, r_out_y}) + (ROW_BITS+2)'(i) - (ROW_BITS+2)'(2);
            if (rr < 0) begin
                rr = '0;
            end
            if (rr > hmax) begin
                rr = hmax;
            end
            rd_slot[i] = rr[SLOT_BITS-1:0];
        end
    end

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_lag    = r_lag;
        n_out_x  = r_out_x;
        n_out_y  = r_out_y;
        n_win    = r_win;
        win1     = r_win;
        mask     = '0;
        rd       = 1'b0;
        if (pix) begin
            win1    = (r_in_col == '0) ? {TAPS{p}} : {p, r_win[TAPS-1:1]};
            mask[0] = r_in_col >= COL_W'(2);
            mask[1] = c_end && (r_in_col != '0);
            mask[2] = c_end;
            if (c_end) begin
                n_win    = {p, p, win1[TAPS-1:2]};
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_win    = win1;
                n_in_col = r_in_col + 1'b1;
            end
        end
        if (!ignore) begin
            if (!lag_full) begin
                n_lag = r_lag + 1'b1;
            end else begin
                rd = 1'b1;
                if (x_end && y_end) begin
                    n_in_col = '0;
                    n_in_row = '0;
                    n_lag    = '0;
                    n_out_x  = '0;
                    n_out_y  = '0;
                end else if (x_end) begin
                    n_out_x = '0;
                    n_out_y = r_out_y + 1'b1;
                end else begin
                    n_out_x = r_out_x + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_lag    <= '0;
            r_out_x  <= '0;
            r_out_y  <= '0;
        end else if (accept) begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_lag    <= n_lag;
            r_out_x  <= n_out_x;
            r_out_y  <= n_out_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    assign o_push        = accept && !ignore && (rd || (mask != '0));
    assign o_cmd.wr_mask = mask;
    assign o_cmd.wr_slot = r_in_row[SLOT_BITS-1:0];
    assign o_cmd.win     = win1;
    assign o_cmd.rd      = rd;
    assign o_cmd.rd_slot = rd_slot;
    assign o_cmd.last    = x_end && y_end;
    assign o_wr_col      = r_in_col;
    assign o_rd_col      = r_out_x;

endmodule

// ----- rtl/core/sgb_back.sv -----
// Back end: horizontal filter into row buffers, vertical filter out of them.
module sgb_back
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int OCW   = $clog2(OUT_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_empty,
    input  t_cmd             i_cmd,
    input  logic [COL_W-1:0] i_wr_col,
    input  logic [COL_W-1:0] i_rd_col,
    output logic             o_cmd_pop,
    input  logic [OCW-1:0]   i_out_count,
    output logic             o_out_push,
    output t_res             o_out_data
);

    logic [2:0] r_done;
    logic [2:0] rem, pick, rem_after;
    logic       op_last, op_rd, credit_ok, issue;
    logic [OCW+1:0] inflight;
    t_win       op_win;
    logic [COL_W-1:0] op_col;

    logic r_a_wr, r_a_rd, r_b_wr, r_b_rd, r_c_wr, r_c_rd, r_d_rd, r_e_rd;
    t_win                           r_a_win;
    logic [SLOT_BITS-1:0]           r_a_wslot, r_b_wslot, r_c_wslot;
    logic [COL_W-1:0]               r_a_wcol, r_b_wcol, r_c_wcol;
    logic [COL_W-1:0]               r_a_rcol, r_b_rcol, r_c_rcol;
    logic [TAPS-1:0][SLOT_BITS-1:0] r_a_rslot, r_b_rslot, r_c_rslot, r_d_rslot;
    logic r_a_last, r_b_last, r_c_last, r_d_last, r_e_last;
    t_prods [2:0] r_b_prod, n_b_prod;
    t_pix         r_c_wdata, n_c_wdata;
    logic [TAPS-1:0] r_d_fwd;
    t_pix         r_d_fdata;
    t_prods [2:0] r_e_prod, n_e_prod;
    logic [ROW_SLOTS-1:0][PIX_BITS-1:0] ram_rdata;

    assign rem       = i_cmd.wr_mask & ~r_done;
    assign pick      = rem[0] ? 3'b001 : (rem[1] ? 3'b010 : (rem[2] ? 3'b100 : 3'b000));
    assign rem_after = rem & ~pick;
    assign op_last   = (rem_after == '0);
    assign op_rd     = i_cmd.rd && op_last;
    assign inflight  = (OCW+2)'(r_a_rd) + (OCW+2)'(r_b_rd) + (OCW+2)'(r_c_rd)
                     + (OCW+2)'(r_d_rd) + (OCW+2)'(r_e_rd);
    assign credit_ok = ((OCW+2)'(i_out_count) + inflight) < (OCW+2)'(OUT_DEPTH);
    assign issue     = !i_cmd_empty && (!op_rd || credit_ok);
    assign o_cmd_pop = issue && op_last;

    always_comb begin
        op_win = i_cmd.win;
        op_col = i_wr_col;
        if (pick[0]) begin
            op_col = i_wr_col - COL_W'(2);
        end else if (pick[1]) begin
            op_win = {i_cmd.win[TAPS-1], i_cmd.win[TAPS-1:1]};
            op_col = i_wr_col - COL_W'(1);
        end else begin
            op_win = {i_cmd.win[TAPS-1], i_cmd.win[TAPS-1], i_cmd.win[TAPS-1:2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_a_wr <= 1'b0;
            r_a_rd <= 1'b0;
            r_b_wr <= 1'b0;
            r_b_rd <= 1'b0;
            r_c_wr <= 1'b0;
            r_c_rd <= 1'b0;
            r_d_rd <= 1'b0;
            r_e_rd <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_done <= '0;
            end else if (issue) begin
                r_done <= r_done | pick;
            end
            r_a_wr <= issue && (pick != '0);
            r_a_rd <= issue && op_rd;
            r_b_wr <= r_a_wr;
            r_b_rd <= r_a_rd;
            r_c_wr <= r_b_wr;
            r_c_rd <= r_b_rd;
            r_d_rd <= r_c_rd;
            r_e_rd <= r_d_rd;
        end
    end

    always_comb begin
        t_chan [TAPS-1:0] v;
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < TAPS; i++) begin
                v[i] = r_a_win[i][c];
            end
            n_b_prod[c] = weigh_taps(v);
        end
        for (int c = 0; c < 3; c++) begin
            n_c_wdata[c] = round_sat(r_b_prod[c]);
        end
    end

    always_comb begin
        t_pix             sel [TAPS];
        t_chan [TAPS-1:0] v;
        for (int i = 0; i < TAPS; i++) begin
            sel[i] = r_d_fwd[i] ? r_d_fdata : t_pix'(ram_rdata[r_d_rslot[i]]);
        end
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < TAPS; i++) begin
                v[i] = sel[i][c];
            end
            n_e_prod[c] = weigh_taps(v);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_win   <= op_win;
        r_a_wslot <= i_cmd.wr_slot;
        r_a_wcol  <= op_col;
        r_a_rcol  <= i_rd_col;
        r_a_rslot <= i_cmd.rd_slot;
        r_a_last  <= i_cmd.last;

        r_b_prod  <= n_b_prod;
        r_b_wslot <= r_a_wslot;
        r_b_wcol  <= r_a_wcol;
        r_b_rcol  <= r_a_rcol;
        r_b_rslot <= r_a_rslot;
        r_b_last  <= r_a_last;

        r_c_wdata <= n_c_wdata;
        r_c_wslot <= r_b_wslot;
        r_c_wcol  <= r_b_wcol;
        r_c_rcol  <= r_b_rcol;
        r_c_rslot <= r_b_rslot;
        r_c_last  <= r_b_last;

        for (int i = 0; i < TAPS; i++) begin
            r_d_fwd[i] <= r_c_wr && (r_c_wslot == r_c_rslot[i]) && (r_c_wcol == r_c_rcol);
        end
        r_d_fdata <= r_c_wdata;
        r_d_rslot <= r_c_rslot;
        r_d_last  <= r_c_last;

        r_e_prod  <= n_e_prod;
        r_e_last  <= r_d_last;
    end

    for (genvar s = 0; s < ROW_SLOTS; s++) begin : g_line
        sgb_ram #(
            .WIDTH (PIX_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_c_wr && (r_c_wslot == SLOT_BITS'(s))),
            .i_waddr (r_c_wcol),
            .i_wdata (PIX_BITS'(r_c_wdata)),
            .i_raddr (r_c_rcol),
            .o_rdata (ram_rdata[s])
        );
    end

    assign o_out_push = r_e_rd;
    always_comb begin
        o_out_data.last = r_e_last;
        for (int c = 0; c < 3; c++) begin
            o_out_data.pix[c] = round_sat(r_e_prod[c]);
        end
    end

    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (i_out_count < OCW'(OUT_DEPTH)))
        else $error("result buffer overflow");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> !i_cmd_empty)
        else $error("command pop on empty queue");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((OCW+2)'(i_out_count) + inflight) <= (OCW+2)'(OUT_DEPTH))
        else $error("result credits exceeded");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_done == '0))
        else $error("write progress not cleared after pop");

endmodule

// ----- rtl/core/separable_gaussian_blur_5tap_core.sv -----
// Top level of the streaming separable 5x5 Gaussian blur with APB configuration.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_op, i_red_in, i_green_in, i_blue_in
//  output    out        o_valid / i_ready   o_red_out, o_green_out, o_blue_out, o_frame_end
//  config    in/out     psel/penable/pready paddr, pwrite, pwdata, prdata
//
//  Drain items and mid-row pixels each need at most one back-end issue; the last pixel of a
//  row needs up to three (three writes through the single write port of that row's buffer
//  when the row has three or more pixels), so frame input can back up at row ends.
//  A result passes through the command queue, back-end stages A to E and the result buffer.
//  Reset is synchronous; the row buffers need no clearing pass.
//  A four-entry command queue and an eight-entry result buffer absorb stalls on either side.
module separable_gaussian_blur_5tap_core
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_red_in,
    input  logic [15:0] i_green_in,
    input  logic [15:0] i_blue_in,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out,
    output logic        o_frame_end,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CQW   = $bits(t_cmd) + 2 * COL_W;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam int CQCW  = $clog2(CMD_DEPTH + 1);

    logic [CFG_WIDTH_BITS-1:0]  r_image_width;
    logic [CFG_HEIGHT_BITS-1:0] r_image_height;
    logic                       cfg_wr, restart;
    t_reg                       cfg_idx;
    logic [WW-1:0]              w_eff;
    logic [ROW_BITS-1:0]        h_eff;

    logic             f_push, q_full, q_empty, q_pop;
    t_cmd             f_cmd, b_cmd;
    logic [COL_W-1:0] f_wr_col, f_rd_col, b_wr_col, b_rd_col;
    logic [CQW-1:0]   q_dout;
    logic [CQCW-1:0]  q_count;

    logic           o_push, o_empty, o_full, o_pop;
    t_res           res_in, res_out;
    logic [OCW-1:0] o_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg'(paddr[2]);
    assign restart = cfg_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_WIDTH_BITS'(RESET_WIDTH);
            r_image_height <= CFG_HEIGHT_BITS'(RESET_HEIGHT);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:  r_image_width  <= pwdata[CFG_WIDTH_BITS-1:0];
                REG_HEIGHT: r_image_height <= pwdata[CFG_HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_image_width);
            REG_HEIGHT: prdata = 32'(r_image_height);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = ROW_BITS'(1);
        end else if (32'(r_image_height) > 32'(HEIGHT_LIMIT)) begin
            h_eff = ROW_BITS'(HEIGHT_LIMIT);
        end else begin
            h_eff = ROW_BITS'(r_image_height);
        end
    end

    sgb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_w       (w_eff),
        .i_h       (h_eff),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_red     (i_red_in),
        .i_green   (i_green_in),
        .i_blue    (i_blue_in),
        .i_q_full  (q_full),
        .o_push    (f_push),
        .o_cmd     (f_cmd),
        .o_wr_col  (f_wr_col),
        .o_rd_col  (f_rd_col)
    );

    sgb_fifo #(
        .WIDTH (CQW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_din   ({f_cmd, f_wr_col, f_rd_col}),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    assign {b_cmd, b_wr_col, b_rd_col} = q_dout;

    sgb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (b_cmd),
        .i_wr_col    (b_wr_col),
        .i_rd_col    (b_rd_col),
        .o_cmd_pop   (q_pop),
        .i_out_count (o_count),
        .o_out_push  (o_push),
        .o_out_data  (res_in)
    );

    sgb_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_push),
        .i_din   (res_in),
        .i_pop   (o_pop),
        .o_dout  (res_out),
        .o_empty (o_empty),
        .o_full  (o_full),
        .o_count (o_count)
    );

    assign o_valid     = !o_empty;
    assign o_pop       = o_valid && i_ready;
    assign o_red_out   = res_out.pix[0];
    assign o_green_out = res_out.pix[1];
    assign o_blue_out  = res_out.pix[2];
    assign o_frame_end = res_out.last;

    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> (q_count == CQCW'(CMD_DEPTH)))
        else $error("command queue count mismatch");

    a_out_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_push)
        else $error("push into full result buffer");

    a_ready_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> o_ready)
        else $error("command issued without room");

endmodule
